// ===== hdl/madt_pkg.sv =====
// shared types and constants for the madt entry stream parser
// no dependencies; imported by the parse core, the result queue and the top level
package madt_pkg;

    // result kinds as seen on the output tuser
    typedef enum logic [2:0] {
        KIND_LAPIC    = 3'd0,
        KIND_IOAPIC   = 3'd1,
        KIND_OVERRIDE = 3'd2,
        KIND_BASE_OVR = 3'd3,
        KIND_SUMMARY  = 3'd4
    } madt_kind_t;

    // entry type codes from the table
    localparam logic [7:0] ET_LAPIC    = 8'd0;
    localparam logic [7:0] ET_IOAPIC   = 8'd1;
    localparam logic [7:0] ET_OVERRIDE = 8'd2;
    localparam logic [7:0] ET_BASE_OVR = 8'd5;

    // minimum entry lengths
    localparam logic [7:0] LEN_MIN      = 8'd2;
    localparam logic [7:0] LEN_LAPIC    = 8'd8;
    localparam logic [7:0] LEN_IOAPIC   = 8'd12;
    localparam logic [7:0] LEN_OVERRIDE = 8'd10;
    localparam logic [7:0] LEN_BASE_OVR = 8'd12;

    // bytes of one entry kept for decoding
    localparam int BUF_BYTES = 12;
    localparam int BUF_IDX_W = 4;

    // register index decoded from paddr[2]
    localparam logic REG_IDX_HEADER_BASE = 1'b0;

    // output tdata width, padded to whole bytes
    localparam int TDATA_W = 104;

    typedef struct packed {
        madt_kind_t   kind;
        logic [4:0]   slot;
        logic [7:0]   field_a;
        logic [7:0]   field_b;
        logic [31:0]  word_a;
        logic [31:0]  word_b;
        logic [15:0]  flag_bits;
        logic         malformed;
        logic         final_res;
    } madt_result_t;

    // configuration write toward the parse core
    typedef struct packed {
        logic         wr;
        logic [31:0]  data;
    } madt_cfg_t;

endpackage

// ===== hdl/madt_parse_core.sv =====
// byte-level entry parser: entry state, decode of completed entries, summary
// depends on madt_pkg; results go to madt_result_queue
module madt_parse_core
    import madt_pkg::*;
#(
    parameter int MAX_CPUS      = 32,
    parameter int MAX_IOAPICS   = 8,
    parameter int MAX_OVERRIDES = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic [31:0]  header_apic_base,
    input  madt_cfg_t    cfg,
    output logic [1:0]   push_n,
    output madt_result_t res0,
    output madt_result_t res1
);

    localparam int CPU_W = $clog2(MAX_CPUS + 1);
    localparam int IO_W  = $clog2(MAX_IOAPICS + 1);
    localparam int OV_W  = $clog2(MAX_OVERRIDES + 1);

    logic [7:0]       off_reg, off_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       len_reg, len_next;
    logic [CPU_W-1:0] cpu_reg, cpu_next;
    logic [IO_W-1:0]  io_reg, io_next;
    logic [OV_W-1:0]  ov_reg, ov_next;
    logic [15:0]      seen_reg, seen_next;
    logic [31:0]      base_reg, base_next;
    logic             halted_reg, halted_next;
    logic             bad_reg, bad_next;

    logic [7:0]       bytes_reg [BUF_BYTES];
    logic [7:0]       bytes_eff [BUF_BYTES];

    logic             step_live;
    logic             finish;
    logic             emit;
    logic [7:0]       len_eff;
    logic [31:0]      cpu_wide, io_wide, ov_wide;
    logic [31:0]      cpu_sum_wide, io_sum_wide;
    madt_result_t     rec;
    madt_result_t     sum;

    assign step_live = step && !halted_reg;

    // entry bytes with the current beat merged at its offset
    always_comb
    begin
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            bytes_eff[i] = (off_reg == 8'(i)) ? data_byte : bytes_reg[i];
        end
    end

    // entry buffer, first BUF_BYTES bytes of the entry including the type and length bytes
    always_ff @(posedge clk)
    begin
        if (step_live && off_reg < 8'(BUF_BYTES))
        begin
            bytes_reg[off_reg[BUF_IDX_W-1:0]] <= data_byte;
        end
    end

    assign cpu_wide = 32'(cpu_reg);
    assign io_wide  = 32'(io_reg);
    assign ov_wide  = 32'(ov_reg);

    // offset tracking and entry completion
    always_comb
    begin
        off_next    = off_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        bad_next    = bad_reg;
        finish      = 1'b0;
        len_eff     = len_reg;
        if (step_live)
        begin
            if (off_reg == 8'd0)
            begin
                type_next = data_byte;
                off_next  = 8'd1;
            end
            else if (off_reg == 8'd1)
            begin
                len_next = data_byte;
                len_eff  = data_byte;
                if (data_byte < LEN_MIN)
                begin
                    bad_next    = 1'b1;
                    halted_next = 1'b1;
                end
                else if (data_byte == LEN_MIN)
                begin
                    finish   = 1'b1;
                    off_next = 8'd0;
                end
                else
                begin
                    off_next = 8'd2;
                    if (last_byte)
                    begin
                        bad_next = 1'b1;
                    end
                end
            end
            else
            begin
                if ({1'b0, off_reg} + 9'd1 >= {1'b0, len_reg})
                begin
                    finish   = 1'b1;
                    off_next = 8'd0;
                end
                else
                begin
                    off_next = off_reg + 8'd1;
                    if (last_byte)
                    begin
                        bad_next = 1'b1;
                    end
                end
            end
        end
    end

    // decode of a completed entry into at most one record, and the header base write
    always_comb
    begin
        emit      = 1'b0;
        rec       = '0;
        cpu_next  = cpu_reg;
        io_next   = io_reg;
        ov_next   = ov_reg;
        seen_next = seen_reg;
        base_next = base_reg;
        // header base reaches the live base only before any byte of a table
        if (!step && cfg.wr && off_reg == 8'd0 && seen_reg == 16'd0 && !halted_reg)
        begin
            base_next = cfg.data;
        end
        if (finish)
        begin
            if (seen_reg != 16'hFFFF)
            begin
                seen_next = seen_reg + 16'd1;
            end
            unique case (type_reg)
                ET_LAPIC:
                begin
                    if (len_eff >= LEN_LAPIC && cpu_reg < CPU_W'(MAX_CPUS))
                    begin
                        emit          = 1'b1;
                        rec.kind      = KIND_LAPIC;
                        rec.slot      = cpu_wide[4:0];
                        rec.field_a   = bytes_eff[2];
                        rec.field_b   = bytes_eff[3];
                        rec.flag_bits = {15'd0, bytes_eff[4][0]};
                        cpu_next      = cpu_reg + CPU_W'(1);
                    end
                end
                ET_IOAPIC:
                begin
                    if (len_eff >= LEN_IOAPIC && io_reg < IO_W'(MAX_IOAPICS))
                    begin
                        emit        = 1'b1;
                        rec.kind    = KIND_IOAPIC;
                        rec.slot    = io_wide[4:0];
                        rec.field_a = bytes_eff[2];
                        rec.word_a  = {bytes_eff[7], bytes_eff[6], bytes_eff[5], bytes_eff[4]};
                        rec.word_b  = {bytes_eff[11], bytes_eff[10], bytes_eff[9], bytes_eff[8]};
                        io_next     = io_reg + IO_W'(1);
                    end
                end
                ET_OVERRIDE:
                begin
                    if (len_eff >= LEN_OVERRIDE && ov_reg < OV_W'(MAX_OVERRIDES))
                    begin
                        emit          = 1'b1;
                        rec.kind      = KIND_OVERRIDE;
                        rec.slot      = ov_wide[4:0];
                        rec.field_a   = bytes_eff[2];
                        rec.field_b   = bytes_eff[3];
                        rec.word_a    = {bytes_eff[7], bytes_eff[6], bytes_eff[5], bytes_eff[4]};
                        rec.flag_bits = {bytes_eff[9], bytes_eff[8]};
                        ov_next       = ov_reg + OV_W'(1);
                    end
                end
                ET_BASE_OVR:
                begin
                    if (len_eff >= LEN_BASE_OVR)
                    begin
                        emit       = 1'b1;
                        base_next  = {bytes_eff[7], bytes_eff[6], bytes_eff[5], bytes_eff[4]};
                        rec.kind   = KIND_BASE_OVR;
                        rec.word_a = {bytes_eff[7], bytes_eff[6], bytes_eff[5], bytes_eff[4]};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cpu_sum_wide = 32'(cpu_next);
    assign io_sum_wide  = 32'(io_next);

    // summary built from the state after this beat
    always_comb
    begin
        sum           = '0;
        sum.kind      = KIND_SUMMARY;
        sum.field_a   = (cpu_sum_wide > 32'd255) ? 8'hFF : cpu_sum_wide[7:0];
        sum.field_b   = (io_sum_wide > 32'd255) ? 8'hFF : io_sum_wide[7:0];
        sum.word_a    = base_next;
        sum.word_b    = {16'd0, seen_next};
        sum.flag_bits = 16'(ov_next);
        sum.malformed = bad_next;
        sum.final_res = 1'b1;
    end

    // result ordering: record first, summary after it
    always_comb
    begin
        res0   = rec;
        res1   = sum;
        push_n = 2'd0;
        if (step)
        begin
            if (emit && last_byte)
            begin
                push_n = 2'd2;
            end
            else if (emit)
            begin
                res0.final_res = 1'b1;
                push_n         = 2'd1;
            end
            else if (last_byte)
            begin
                res0   = sum;
                push_n = 2'd1;
            end
        end
    end

    // parse state, rearmed by the last beat of a table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= 8'd0;
            type_reg   <= 8'd0;
            len_reg    <= 8'd0;
            cpu_reg    <= '0;
            io_reg     <= '0;
            ov_reg     <= '0;
            seen_reg   <= 16'd0;
            base_reg   <= 32'd0;
            halted_reg <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else if (step && last_byte)
        begin
            off_reg    <= 8'd0;
            type_reg   <= 8'd0;
            len_reg    <= 8'd0;
            cpu_reg    <= '0;
            io_reg     <= '0;
            ov_reg     <= '0;
            seen_reg   <= 16'd0;
            base_reg   <= header_apic_base;
            halted_reg <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            off_reg    <= off_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            cpu_reg    <= cpu_next;
            io_reg     <= io_next;
            ov_reg     <= ov_next;
            seen_reg   <= seen_next;
            base_reg   <= base_next;
            halted_reg <= halted_next;
            bad_reg    <= bad_next;
        end
    end

    // the last beat always leaves a clean, running parser
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> (off_reg == 8'd0 && !halted_reg && !bad_reg
                                 && seen_reg == 16'd0))
        else $error("parser not rearmed after last beat");

    // a halted parser only ever yields the summary
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && halted_reg) |-> (push_n == (last_byte ? 2'd1 : 2'd0)))
        else $error("record emitted while halted");

    // a pair is record then summary, final flag on the second only
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (res1.kind == KIND_SUMMARY && res1.final_res
                              && !res0.final_res && res0.kind != KIND_SUMMARY))
        else $error("bad result pair order");

endmodule

// ===== hdl/madt_result_queue.sv =====
// three-entry result queue between the parse core and the output stream
// depends on madt_pkg; takes up to two results per beat, gives one per cycle while the output is ready
module madt_result_queue
    import madt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_n,
    input  madt_result_t res0,
    input  madt_result_t res1,
    output logic         out_valid,
    input  logic         out_ready,
    output madt_result_t head,
    output logic         in_ready
);

    localparam int DEPTH = 3;

    madt_result_t q_reg [DEPTH];
    madt_result_t q_next [DEPTH];
    logic [1:0]   count_reg, count_next;
    logic [1:0]   count_left;
    logic         pop;

    assign out_valid = (count_reg != 2'd0);
    assign head      = q_reg[0];
    assign pop       = out_valid && out_ready;
    // room for a full pair regardless of the output side
    assign in_ready  = (count_reg <= 2'd1);

    assign count_left = count_reg - {1'b0, pop};
    assign count_next = count_left + push_n;

    // shift out the head, then append at the tail
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push_n != 2'd0 && count_left == 2'(i))
            begin
                q_next[i] = res0;
            end
            if (push_n == 2'd2 && count_left + 2'd1 == 2'(i))
            begin
                q_next[i] = res1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // a pair only lands when at least two slots are free
    a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (count_reg <= 2'd1))
        else $error("result pair pushed without room");

    // a lone pop drains one entry
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue count wrong after pop");

    // a lone push adds one entry
    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop && push_n == 2'd1) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count wrong after push");

endmodule

// ===== hdl/madt_entry_stream_parser.sv =====
// top level of the madt entry stream parser: stream ports, apb register, wiring
// depends on madt_pkg, madt_parse_core and madt_result_queue
//
// Takes the entry area of an ACPI MADT one byte per beat (tlast on the final
// byte) and emits a record for each long enough local APIC, I/O APIC,
// interrupt override and APIC address override entry (the first three up to
// their MAX_ parameter limits), followed on the last byte by a summary. One
// byte is taken every clock cycle while the result queue has room for two
// results. A last byte that also completes an emitted entry yields two
// results, which leaves the three-entry queue too full for another pair, so
// the input pauses after such a beat even with the output always ready;
// beyond that the input stalls only when the output is held back.
// header_apic_base sits at byte address 0 and should be written between tables.
module madt_entry_stream_parser
    import madt_pkg::*;
#(
    parameter int MAX_CPUS      = 32,
    parameter int MAX_IOAPICS   = 8,
    parameter int MAX_OVERRIDES = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // last_byte
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] slot, [12:5] field_a, [20:13] field_b, [52:21] word_a,
    // [84:53] word_b, [100:85] flag_bits, [101] malformed, [103:102] zero
    output logic [TDATA_W-1:0]  m_tdata,
    output logic [2:0]          m_tuser,   // [2:0] kind
    output logic                m_tlast,   // final_res
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [31:0]  header_base_reg, header_base_next;
    madt_cfg_t    cfg;
    logic         step;
    logic [1:0]   push_n;
    madt_result_t res0;
    madt_result_t res1;
    madt_result_t head;

    // apb register
    assign pready = 1'b1;
    assign cfg.wr = psel && penable && pwrite && (paddr[2] == REG_IDX_HEADER_BASE);
    assign cfg.data = pwdata;
    assign header_base_next = cfg.wr ? pwdata : header_base_reg;
    assign prdata = (paddr[2] == REG_IDX_HEADER_BASE) ? header_base_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_base_reg <= 32'd0;
        end
        else
        begin
            header_base_reg <= header_base_next;
        end
    end

    // accepted input beat
    assign step = s_tvalid && s_tready;

    madt_parse_core #(
        .MAX_CPUS      (MAX_CPUS),
        .MAX_IOAPICS   (MAX_IOAPICS),
        .MAX_OVERRIDES (MAX_OVERRIDES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .data_byte        (s_tdata),
        .last_byte        (s_tlast),
        .header_apic_base (header_base_reg),
        .cfg              (cfg),
        .push_n           (push_n),
        .res0             (res0),
        .res1             (res1)
    );

    madt_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .res0      (res0),
        .res1      (res1),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head),
        .in_ready  (s_tready)
    );

    // output packing
    assign m_tuser = head.kind;
    assign m_tlast = head.final_res;
    assign m_tdata = {2'b00, head.malformed, head.flag_bits, head.word_b, head.word_a,
                      head.field_b, head.field_a, head.slot};

endmodule
